// ===== src/sla_pkg.sv =====
package sla_pkg;

  // Function codes carried by an input beat.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_MODE  = 2'd1;
  localparam logic [1:0] FUNC_COLOR = 2'd2;

  // Status modes.
  localparam logic [3:0] MODE_OFF         = 4'd0;
  localparam logic [3:0] MODE_IDLE        = 4'd1;
  localparam logic [3:0] MODE_READING     = 4'd2;
  localparam logic [3:0] MODE_WIFI        = 4'd3;
  localparam logic [3:0] MODE_BLE         = 4'd4;
  localparam logic [3:0] MODE_RECORDING   = 4'd5;
  localparam logic [3:0] MODE_LOW_BATTERY = 4'd6;
  localparam logic [3:0] MODE_ERROR       = 4'd7;
  localparam logic [3:0] MODE_SUCCESS     = 4'd8;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_FLOOR    = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] PULSE_INTERVAL_RST = 16'd30;
  localparam logic [15:0] BLINK_INTERVAL_RST = 16'd500;
  localparam logic [7:0]  PULSE_FLOOR_RST    = 8'd30;

  localparam logic [7:0] PULSE_STEP = 8'd5;
  localparam logic [7:0] LEVEL_MAX  = 8'd255;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  localparam rgb_t RGB_BLACK = '{r: 8'd0, g: 8'd0, b: 8'd0};

  typedef struct packed {
    logic [15:0] pulse_interval;
    logic [15:0] blink_interval;
    logic [7:0]  pulse_floor;
  } sla_cfg_t;

  typedef struct packed {
    logic [3:0]  mode;
    rgb_t        color;
    logic [31:0] last_ms;
    logic        rising;
    logic [7:0]  level;
  } sla_state_t;

  // Fixed color of each status mode; codes without meaning return black
  // and are never used to load the pixel.
  function automatic rgb_t mode_color(input logic [3:0] m);
    rgb_t c;
    c = RGB_BLACK;
    unique case (m)
      MODE_OFF:         c = RGB_BLACK;
      MODE_IDLE:        c = '{r: 8'd0,   g: 8'd30,  b: 8'd0};
      MODE_READING:     c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
      MODE_WIFI:        c = '{r: 8'd0,   g: 8'd255, b: 8'd255};
      MODE_BLE:         c = '{r: 8'd128, g: 8'd0,   b: 8'd255};
      MODE_RECORDING:   c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
      MODE_LOW_BATTERY: c = '{r: 8'd255, g: 8'd100, b: 8'd0};
      MODE_ERROR:       c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
      MODE_SUCCESS:     c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
      default:          c = RGB_BLACK;
    endcase
    return c;
  endfunction

  function automatic logic mode_known(input logic [3:0] m);
    return m <= MODE_SUCCESS;
  endfunction

endpackage

// ===== src/status_led_animator.sv =====
// Output: each accepted input beat loads the output register with its result beat.
// Throughput: one input beat per cycle; the single output register is refilled
// in the same cycle its beat is taken, so only out_stall on a valid beat blocks input.
// Reset: synchronous active-low rst_n clears the output valid, loads the mode,
// pixel and animation state to off/black/rising, and the registers to defaults.
module status_led_animator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_func,
  input  logic [31:0]                      in_now_ms,
  input  logic [3:0]                       in_mode,
  input  logic [7:0]                       in_red_in,
  input  logic [7:0]                       in_green_in,
  input  logic [7:0]                       in_blue_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic                             out_refresh,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sla_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sla_pkg::sla_state_t state_r;
  sla_pkg::sla_state_t state_nxt;
  sla_pkg::sla_cfg_t   cfg_r;
  logic                refresh_nxt;
  logic                in_take;
  logic                out_valid_r;
  sla_pkg::rgb_t       out_color_r;
  logic                out_refresh_r;

  assign in_stall  = out_valid_r && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  sla_step u_step (
    .state     (state_r),
    .cfg       (cfg_r),
    .func      (in_func),
    .now_ms    (in_now_ms),
    .mode      (in_mode),
    .red_in    (in_red_in),
    .green_in  (in_green_in),
    .blue_in   (in_blue_in),
    .state_nxt (state_nxt),
    .refresh   (refresh_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_interval <= sla_pkg::PULSE_INTERVAL_RST;
      cfg_r.blink_interval <= sla_pkg::BLINK_INTERVAL_RST;
      cfg_r.pulse_floor    <= sla_pkg::PULSE_FLOOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sla_pkg::CFG_PULSE_INTERVAL: cfg_r.pulse_interval <= cfg_data;
        sla_pkg::CFG_BLINK_INTERVAL: cfg_r.blink_interval <= cfg_data;
        sla_pkg::CFG_PULSE_FLOOR:    cfg_r.pulse_floor    <= cfg_data[7:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode    <= sla_pkg::MODE_OFF;
      state_r.color   <= sla_pkg::RGB_BLACK;
      state_r.last_ms <= 32'd0;
      state_r.rising  <= 1'b1;
      state_r.level   <= 8'd0;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_color_r   <= state_nxt.color;
      out_refresh_r <= refresh_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_red     = out_color_r.r;
  assign out_green   = out_color_r.g;
  assign out_blue    = out_color_r.b;
  assign out_refresh = out_refresh_r;

endmodule

// ===== src/sla_step.sv =====
module sla_step (
  input  sla_pkg::sla_state_t state,
  input  sla_pkg::sla_cfg_t   cfg,
  input  logic [1:0]          func,
  input  logic [31:0]         now_ms,
  input  logic [3:0]          mode,
  input  logic [7:0]          red_in,
  input  logic [7:0]          green_in,
  input  logic [7:0]          blue_in,
  output sla_pkg::sla_state_t state_nxt,
  output logic                refresh
);

  logic [31:0] elapsed;
  logic        pulse_due;
  logic        blink_due;
  logic [7:0]  level_up;
  logic [7:0]  level_dn;

  assign elapsed   = now_ms - state.last_ms;
  assign pulse_due = elapsed > {16'd0, cfg.pulse_interval};
  assign blink_due = elapsed > {16'd0, cfg.blink_interval};

  // Rise saturates at full scale, fall stops at zero.
  assign level_up = (state.level > (sla_pkg::LEVEL_MAX - sla_pkg::PULSE_STEP)) ?
                    sla_pkg::LEVEL_MAX : state.level + sla_pkg::PULSE_STEP;
  assign level_dn = (state.level < sla_pkg::PULSE_STEP) ?
                    8'd0 : state.level - sla_pkg::PULSE_STEP;

  always_comb begin
    state_nxt = state;
    refresh   = 1'b0;
    unique case (func)
      sla_pkg::FUNC_TICK: begin
        if (state.mode == sla_pkg::MODE_RECORDING && pulse_due) begin
          state_nxt.last_ms = now_ms;
          refresh           = 1'b1;
          if (state.rising) begin
            state_nxt.level = level_up;
            if (level_up == sla_pkg::LEVEL_MAX) begin
              state_nxt.rising = 1'b0;
            end
          end else begin
            state_nxt.level = level_dn;
            if (level_dn <= cfg.pulse_floor) begin
              state_nxt.rising = 1'b1;
            end
          end
          state_nxt.color = '{r: state_nxt.level, g: 8'd0, b: 8'd0};
        end else if (state.mode == sla_pkg::MODE_LOW_BATTERY && blink_due) begin
          state_nxt.last_ms = now_ms;
          refresh           = 1'b1;
          if (state.color.r != 8'd0) begin
            state_nxt.color = sla_pkg::RGB_BLACK;
          end else begin
            state_nxt.color = sla_pkg::mode_color(sla_pkg::MODE_LOW_BATTERY);
          end
        end
      end
      sla_pkg::FUNC_MODE: begin
        state_nxt.mode = mode;
        if (sla_pkg::mode_known(mode)) begin
          state_nxt.color = sla_pkg::mode_color(mode);
        end
        refresh = 1'b1;
      end
      sla_pkg::FUNC_COLOR: begin
        state_nxt.mode  = sla_pkg::MODE_OFF;
        state_nxt.color = '{r: red_in, g: green_in, b: blue_in};
        refresh         = 1'b1;
      end
      default: begin
        // Unused function code: state holds and no refresh is reported.
        refresh = 1'b0;
      end
    endcase
  end

endmodule
